// ===== sv/jils_pkg.sv =====
package jils_pkg;

    // build-time defaults for the top level parameters
    localparam int SAMPLE_MAX_DEF  = 64;
    localparam int MIN_SAMPLES_DEF = 4;

    // sample rate register after reset
    localparam logic [15:0] RATE_RST = 16'd1000;

    // width of the exact solve terms (determinant and numerators)
    localparam int WIDE_W = 130;

    // request codes; bit 1 set means restart
    localparam logic [1:0] REQ_PUSH    = 2'd0;
    localparam logic [1:0] REQ_SOLVE   = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // result status codes
    localparam logic [2:0] ST_FIRST    = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_SOLVED   = 3'd3;
    localparam logic [2:0] ST_TOO_FEW  = 3'd4;
    localparam logic [2:0] ST_SINGULAR = 3'd5;

endpackage

// ===== sv/jils_div.sv =====
module jils_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [jils_pkg::WIDE_W-1:0]   i_num,
    input  logic [jils_pkg::WIDE_W-1:0]   i_den,
    output logic                          o_done,
    output logic [31:0]                   o_quot
);
    import jils_pkg::*;

    localparam int RW = WIDE_W + 32;

    logic [RW-1:0] r_rem, n_rem;
    logic [RW-1:0] r_dsr, n_dsr;
    logic [32:0]   r_q, n_q;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_neg, n_neg;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [31:0]   r_quot, n_quot;

    logic [WIDE_W-1:0] mag_n;
    logic [WIDE_W-1:0] mag_d;
    logic              ge;

    // magnitudes of the signed operands
    assign mag_n = i_num[WIDE_W-1] ? (~i_num + 1'b1) : i_num;
    assign mag_d = i_den[WIDE_W-1] ? (~i_den + 1'b1) : i_den;
    assign ge    = (r_rem >= r_dsr);

    // restoring division, one quotient bit a cycle, 33 bits in all
    always_comb begin
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_busy = r_busy;
        n_done = 1'b0;
        n_quot = r_quot;
        if (i_start) begin
            n_rem  = RW'(mag_n) << 16;
            n_dsr  = RW'(mag_d) << 32;
            n_q    = '0;
            n_cnt  = 6'd32;
            n_neg  = i_num[WIDE_W-1] ^ i_den[WIDE_W-1];
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (ge) begin
                n_rem = r_rem - r_dsr;
            end
            n_q   = {r_q[31:0], ge};
            n_dsr = r_dsr >> 1;
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                // saturate to the signed 32-bit range
                if (n_neg) begin
                    n_quot = (n_q > 33'h080000000) ? 32'h80000000 : (32'd0 - n_q[31:0]);
                end else begin
                    n_quot = (n_q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : n_q[31:0];
                end
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sv/joint_inertia_least_squares.sv =====
// Joint inertia and viscous damping estimator. A request is taken when i_start is high and
// o_busy low; its single result appears for one cycle with o_valid and cannot be held off.
// Restart, first-frame and full-buffer requests are answered straight from idle. A push uses
// one shared 32x32 multiplier for the acceleration and then the five products in turn; the
// push that fills the buffer goes on into a solve. A solve uses the same multiplier for the 2x2
// determinant and numerators from 32-bit partial products, then a bit-serial divider forms
// each of the two estimates in turn. The user must write the sample rate register through
// i_cfg_we / i_cfg_data only while no request is in progress; the block does not enforce it.
module joint_inertia_least_squares #(
    parameter int SAMPLE_MAX  = jils_pkg::SAMPLE_MAX_DEF,
    parameter int MIN_SAMPLES = jils_pkg::MIN_SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_req_type,
    input  logic signed [15:0] i_velocity,
    input  logic signed [15:0] i_torque,
    input  logic signed [15:0] i_torque_ff,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [6:0]         o_sample_count,
    output logic signed [31:0] o_inertia_est,
    output logic signed [31:0] o_damping_est,
    output logic               o_estimate_ready
);
    import jils_pkg::*;

    localparam logic [6:0] CNT_MAX = 7'(SAMPLE_MAX);
    localparam logic [6:0] CNT_MIN = 7'(MIN_SAMPLES);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_AMUL = 4'd1;
    localparam logic [3:0] S_AFIX = 4'd2;
    localparam logic [3:0] S_PMUL = 4'd3;
    localparam logic [3:0] S_PADD = 4'd4;
    localparam logic [3:0] S_SCHK = 4'd5;
    localparam logic [3:0] S_SMAG = 4'd6;
    localparam logic [3:0] S_SMUL = 4'd7;
    localparam logic [3:0] S_SADD = 4'd8;
    localparam logic [3:0] S_DIVJ = 4'd9;
    localparam logic [3:0] S_DIVB = 4'd10;

    localparam logic [63:0] POS_MAX = 64'h7FFFFFFFFFFFFFFF;
    localparam logic [63:0] NEG_MAX = 64'h8000000000000000;

    // control and identification state
    logic [3:0]  r_state, n_state;
    logic [15:0] r_rate, n_rate;
    logic        r_ffp, n_ffp;
    logic [15:0] r_prev, n_prev;
    logic [6:0]  r_count, n_count;
    logic [63:0] r_saa, n_saa, r_sav, n_sav, r_svv, n_svv, r_sat, n_sat, r_svt, n_svt;
    logic [31:0] r_inertia, n_inertia, r_damping, n_damping;
    logic        r_ready, n_ready;
    logic        r_valid, n_valid;
    logic [2:0]  r_status, n_status;
    logic        r_div_go, n_div_go;

    // working registers
    logic [16:0] r_diff_mag, n_diff_mag;
    logic        r_diff_neg, n_diff_neg;
    logic [15:0] r_vel_mag, n_vel_mag;
    logic        r_vel_neg, n_vel_neg;
    logic [16:0] r_tgt_mag, n_tgt_mag;
    logic        r_tgt_neg, n_tgt_neg;
    logic [31:0] r_acc_mag, n_acc_mag;
    logic [2:0]  r_term, n_term;
    logic [63:0] r_pp, n_pp;
    logic        r_tneg, n_tneg;
    logic [63:0] r_mx, n_mx, r_my, n_my;
    logic [1:0]  r_pidx, n_pidx;
    logic        r_half, n_half;
    logic [1:0]  r_phase, n_phase;
    logic [WIDE_W-1:0] r_wacc, n_wacc, r_det, n_det, r_nj, n_nj;

    // combinational
    logic [16:0] diff, tgt;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] ta, tb;
    logic        tsa, tsb;
    logic [63:0] sx, sy;
    logic [63:0] prod, old_sum, new_sum, add_s;
    logic [WIDE_W-1:0] shp, add_w;
    logic [6:0]  cnt_inc;
    logic        div_done;
    logic [31:0] div_quot;

    assign diff    = {i_velocity[15], i_velocity} - {r_prev[15], r_prev};
    assign tgt     = {i_torque[15], i_torque} - {i_torque_ff[15], i_torque_ff};
    assign cnt_inc = r_count + 7'd1;

    // push product operands by term
    always_comb begin
        case (r_term)
            3'd0: begin ta = r_acc_mag; tb = r_acc_mag; tsa = r_diff_neg; tsb = r_diff_neg; end
            3'd1: begin ta = r_acc_mag; tb = 32'(r_vel_mag); tsa = r_diff_neg; tsb = r_vel_neg; end
            3'd2: begin
                ta = 32'(r_vel_mag); tb = 32'(r_vel_mag); tsa = r_vel_neg; tsb = r_vel_neg;
            end
            3'd3: begin ta = r_acc_mag; tb = 32'(r_tgt_mag); tsa = r_diff_neg; tsb = r_tgt_neg; end
            3'd4: begin
                ta = 32'(r_vel_mag); tb = 32'(r_tgt_mag); tsa = r_vel_neg; tsb = r_tgt_neg;
            end
            default: begin ta = '0; tb = '0; tsa = 1'b0; tsb = 1'b0; end
        endcase
    end

    // solve operands: determinant, inertia numerator, damping numerator
    always_comb begin
        case ({r_phase, r_half})
            3'b000:  begin sx = r_saa; sy = r_svv; end
            3'b001:  begin sx = r_sav; sy = r_sav; end
            3'b010:  begin sx = r_sat; sy = r_svv; end
            3'b011:  begin sx = r_sav; sy = r_svt; end
            3'b100:  begin sx = r_saa; sy = r_svt; end
            3'b101:  begin sx = r_sav; sy = r_sat; end
            default: begin sx = r_saa; sy = r_svv; end
        endcase
    end

    // the shared multiplier
    always_comb begin
        case (r_state)
            S_AMUL: begin mul_a = 32'(r_diff_mag); mul_b = 32'(r_rate); end
            S_PMUL: begin mul_a = ta; mul_b = tb; end
            S_SMUL: begin
                mul_a = r_pidx[0] ? r_mx[63:32] : r_mx[31:0];
                mul_b = r_pidx[1] ? r_my[63:32] : r_my[31:0];
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // saturating signed product and sum
    always_comb begin
        if (r_tneg) begin
            prod = (r_pp > NEG_MAX) ? NEG_MAX : (64'd0 - r_pp);
        end else begin
            prod = (r_pp > POS_MAX) ? POS_MAX : r_pp;
        end
        case (r_term)
            3'd0:    old_sum = r_saa;
            3'd1:    old_sum = r_sav;
            3'd2:    old_sum = r_svv;
            3'd3:    old_sum = r_sat;
            3'd4:    old_sum = r_svt;
            default: old_sum = r_saa;
        endcase
        add_s = old_sum + prod;
        if ((old_sum[63] == prod[63]) && (add_s[63] != old_sum[63])) begin
            new_sum = old_sum[63] ? NEG_MAX : POS_MAX;
        end else begin
            new_sum = add_s;
        end
    end

    // partial product placed into the wide accumulator
    always_comb begin
        case (2'(r_pidx[0]) + 2'(r_pidx[1]))
            2'd0:    shp = {66'd0, r_pp};
            2'd1:    shp = {34'd0, r_pp, 32'd0};
            2'd2:    shp = {2'd0, r_pp, 64'd0};
            default: shp = '0;
        endcase
        add_w = r_tneg ? (r_wacc - shp) : (r_wacc + shp);
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_rate     = i_cfg_we ? i_cfg_data : r_rate;
        n_ffp      = r_ffp;
        n_prev     = r_prev;
        n_count    = r_count;
        n_saa      = r_saa;
        n_sav      = r_sav;
        n_svv      = r_svv;
        n_sat      = r_sat;
        n_svt      = r_svt;
        n_inertia  = r_inertia;
        n_damping  = r_damping;
        n_ready    = r_ready;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_div_go   = 1'b0;
        n_diff_mag = r_diff_mag;
        n_diff_neg = r_diff_neg;
        n_vel_mag  = r_vel_mag;
        n_vel_neg  = r_vel_neg;
        n_tgt_mag  = r_tgt_mag;
        n_tgt_neg  = r_tgt_neg;
        n_acc_mag  = r_acc_mag;
        n_term     = r_term;
        n_pp       = r_pp;
        n_tneg     = r_tneg;
        n_mx       = r_mx;
        n_my       = r_my;
        n_pidx     = r_pidx;
        n_half     = r_half;
        n_phase    = r_phase;
        n_wacc     = r_wacc;
        n_det      = r_det;
        n_nj       = r_nj;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req_type[1]) begin
                        // restart identification
                        n_ffp     = 1'b1;
                        n_prev    = '0;
                        n_count   = '0;
                        n_saa     = '0;
                        n_sav     = '0;
                        n_svv     = '0;
                        n_sat     = '0;
                        n_svt     = '0;
                        n_inertia = '0;
                        n_damping = '0;
                        n_ready   = 1'b0;
                        n_status  = ST_FIRST;
                        n_valid   = 1'b1;
                    end else if (i_req_type == REQ_SOLVE) begin
                        n_state = S_SCHK;
                    end else if (r_ffp) begin
                        n_prev   = i_velocity;
                        n_ffp    = 1'b0;
                        n_status = ST_FIRST;
                        n_valid  = 1'b1;
                    end else if (r_count >= CNT_MAX) begin
                        n_status = ST_FULL;
                        n_valid  = 1'b1;
                    end else begin
                        n_prev     = i_velocity;
                        n_diff_neg = diff[16];
                        n_diff_mag = diff[16] ? (~diff + 17'd1) : diff;
                        n_vel_neg  = i_velocity[15];
                        n_vel_mag  = i_velocity[15] ? (16'd0 - i_velocity) : i_velocity;
                        n_tgt_neg  = tgt[16];
                        n_tgt_mag  = tgt[16] ? (~tgt + 17'd1) : tgt;
                        n_state    = S_AMUL;
                    end
                end
            end
            S_AMUL: begin
                n_pp    = mul_p;
                n_state = S_AFIX;
            end
            S_AFIX: begin
                n_acc_mag = r_pp[31:0];
                n_term    = '0;
                n_state   = S_PMUL;
            end
            S_PMUL: begin
                n_pp    = mul_p;
                n_tneg  = tsa ^ tsb;
                n_state = S_PADD;
            end
            S_PADD: begin
                case (r_term)
                    3'd0:    n_saa = new_sum;
                    3'd1:    n_sav = new_sum;
                    3'd2:    n_svv = new_sum;
                    3'd3:    n_sat = new_sum;
                    3'd4:    n_svt = new_sum;
                    default: n_saa = r_saa;
                endcase
                if (r_term == 3'd4) begin
                    n_count = cnt_inc;
                    if (cnt_inc >= CNT_MAX) begin
                        n_state = S_SCHK;
                    end else begin
                        n_status = ST_ACCEPTED;
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_term  = r_term + 3'd1;
                    n_state = S_PMUL;
                end
            end
            S_SCHK: begin
                if (r_count < CNT_MIN) begin
                    n_status = ST_TOO_FEW;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_wacc  = '0;
                    n_phase = '0;
                    n_half  = 1'b0;
                    n_state = S_SMAG;
                end
            end
            S_SMAG: begin
                n_mx    = sx[63] ? (64'd0 - sx) : sx;
                n_my    = sy[63] ? (64'd0 - sy) : sy;
                n_tneg  = sx[63] ^ sy[63] ^ r_half;
                n_pidx  = '0;
                n_state = S_SMUL;
            end
            S_SMUL: begin
                n_pp    = mul_p;
                n_state = S_SADD;
            end
            S_SADD: begin
                n_wacc = add_w;
                if (r_pidx != 2'd3) begin
                    n_pidx  = r_pidx + 2'd1;
                    n_state = S_SMUL;
                end else if (!r_half) begin
                    n_half  = 1'b1;
                    n_state = S_SMAG;
                end else begin
                    n_half = 1'b0;
                    case (r_phase)
                        2'd0: begin
                            n_det = add_w;
                            if (add_w == '0) begin
                                n_status = ST_SINGULAR;
                                n_valid  = 1'b1;
                                n_state  = S_IDLE;
                            end else begin
                                n_wacc  = '0;
                                n_phase = 2'd1;
                                n_state = S_SMAG;
                            end
                        end
                        2'd1: begin
                            n_nj    = add_w;
                            n_wacc  = '0;
                            n_phase = 2'd2;
                            n_state = S_SMAG;
                        end
                        default: begin
                            n_div_go = 1'b1;
                            n_state  = S_DIVJ;
                        end
                    endcase
                end
            end
            S_DIVJ: begin
                if (div_done) begin
                    n_inertia = div_quot;
                    n_div_go  = 1'b1;
                    n_state   = S_DIVB;
                end
            end
            S_DIVB: begin
                if (div_done) begin
                    n_damping = div_quot;
                    n_ready   = 1'b1;
                    n_status  = ST_SOLVED;
                    n_valid   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // divider shared by both estimates
    jils_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   ((r_state == S_DIVJ) ? r_nj : r_wacc),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rate    <= RATE_RST;
            r_ffp     <= 1'b1;
            r_prev    <= '0;
            r_count   <= '0;
            r_saa     <= '0;
            r_sav     <= '0;
            r_svv     <= '0;
            r_sat     <= '0;
            r_svt     <= '0;
            r_inertia <= '0;
            r_damping <= '0;
            r_ready   <= 1'b0;
            r_valid   <= 1'b0;
            r_status  <= ST_FIRST;
            r_div_go  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rate    <= n_rate;
            r_ffp     <= n_ffp;
            r_prev    <= n_prev;
            r_count   <= n_count;
            r_saa     <= n_saa;
            r_sav     <= n_sav;
            r_svv     <= n_svv;
            r_sat     <= n_sat;
            r_svt     <= n_svt;
            r_inertia <= n_inertia;
            r_damping <= n_damping;
            r_ready   <= n_ready;
            r_valid   <= n_valid;
            r_status  <= n_status;
            r_div_go  <= n_div_go;
        end
    end

    // working datapath registers
    always_ff @(posedge i_clk) begin
        r_diff_mag <= n_diff_mag;
        r_diff_neg <= n_diff_neg;
        r_vel_mag  <= n_vel_mag;
        r_vel_neg  <= n_vel_neg;
        r_tgt_mag  <= n_tgt_mag;
        r_tgt_neg  <= n_tgt_neg;
        r_acc_mag  <= n_acc_mag;
        r_term     <= n_term;
        r_pp       <= n_pp;
        r_tneg     <= n_tneg;
        r_mx       <= n_mx;
        r_my       <= n_my;
        r_pidx     <= n_pidx;
        r_half     <= n_half;
        r_phase    <= n_phase;
        r_wacc     <= n_wacc;
        r_det      <= n_det;
        r_nj       <= n_nj;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_sample_count   = r_count;
    assign o_inertia_est    = r_inertia;
    assign o_damping_est    = r_damping;
    assign o_estimate_ready = r_ready;

endmodule

// ===== sv/jils_checker.sv =====
module jils_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [15:0] i_cfg_data,
    input logic        i_start,
    input logic        o_busy,
    input logic [1:0]  i_req_type,
    input logic [15:0] i_velocity,
    input logic [15:0] i_torque,
    input logic [15:0] i_torque_ff,
    input logic        o_valid,
    input logic [2:0]  o_status,
    input logic [6:0]  o_sample_count,
    input logic [31:0] o_inertia_est,
    input logic [31:0] o_damping_est,
    input logic        o_estimate_ready
);
    import jils_pkg::*;

    // an accepted request is either in progress or answered next cycle
    a_req_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_valid))
        else $error("request neither in progress nor answered");

    // a result only appears once the block is free again
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while busy");

    // a first frame result shows no gathered samples and no ready estimate
    a_first_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FIRST)) |-> ((o_sample_count == 7'd0) && !o_estimate_ready))
        else $error("first frame status with gathered samples");

    // a successful solve leaves the estimate flagged ready
    a_solved_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_SOLVED)) |-> o_estimate_ready)
        else $error("solved without estimate ready");

endmodule

bind joint_inertia_least_squares jils_assertions u_jils_assertions (.*);
